// File: sv/mbe_pkg.sv
// mbe_pkg: shared types and constants for the escape-time block
// no dependencies; imported by every module of the block except mbe_mul

package mbe_pkg;

   localparam int COORD_PORT_WIDTH = 32;
   localparam int COUNT_PORT_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH   = 32;
   localparam int LIMIT_WIDTH      = 16;
   localparam int RADIUS_WIDTH     = 32;

   localparam logic [LIMIT_WIDTH-1:0]  ITER_LIMIT_RESET       = 16'd256;
   localparam logic [RADIUS_WIDTH-1:0] ESCAPE_RADIUS_SQ_RESET = 32'd67108864;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ITER_LIMIT       = 4'd0,
      CSR_ESCAPE_RADIUS_SQ = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0]  iter_limit;
      logic [RADIUS_WIDTH-1:0] escape_radius_sq;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_XX,
      ST_MUL_YY,
      ST_MUL_XY,
      ST_TEST,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

// File: sv/mandelbrot_escape_time.sv
// mandelbrot_escape_time: top level of the escape-time block
// depends on mbe_pkg, mbe_csr, mbe_core (which holds mbe_mul)

// One point is taken when start is high and busy is low; busy then stays high
// until the result strobe. All arithmetic runs through one signed multiplier
// that is used three times per iteration, and the number of z updates for an
// item is at most the configured iteration limit. The next item can be
// accepted in the cycle after the strobe. rsp_valid is high for exactly one
// cycle and the result must be captured then: there is no way to hold it off.
// Configuration writes are always accepted and should only be made while busy
// is low.

module mandelbrot_escape_time #(
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [mbe_pkg::COORD_PORT_WIDTH-1:0] req_c_real,
   input  logic signed [mbe_pkg::COORD_PORT_WIDTH-1:0] req_c_imag,
   output logic                                 rsp_valid,
   output logic [mbe_pkg::COUNT_PORT_WIDTH-1:0] rsp_iteration_count,
   output logic                                 rsp_in_set,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mbe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mbe_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   import mbe_pkg::*;

   cfg_type                       cfg;
   logic signed [COORD_WIDTH-1:0] c_real;
   logic signed [COORD_WIDTH-1:0] c_imag;
   logic [COUNT_WIDTH-1:0]        count;
   logic                          core_busy;
   logic                          core_done;
   logic                          core_in_set;

   assign c_real = req_c_real[COORD_WIDTH-1:0];
   assign c_imag = req_c_imag[COORD_WIDTH-1:0];

   mbe_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   mbe_core #(
      .COORD_WIDTH(COORD_WIDTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .c_real         (c_real),
      .c_imag         (c_imag),
      .cfg            (cfg),
      .busy           (core_busy),
      .done           (core_done),
      .iteration_count(count),
      .in_set         (core_in_set)
   );

   assign busy                = core_busy;
   assign rsp_valid           = core_done;
   assign rsp_iteration_count = COUNT_PORT_WIDTH'(count);
   assign rsp_in_set          = core_in_set;

endmodule

// File: sv/mbe_mul.sv
// mbe_mul: shared signed fixed-point multiplier with registered, rescaled product
// depends on mbe_pkg only by convention; no package items used

module mbe_mul #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic signed [COORD_WIDTH-1:0] op_a,
   input  logic signed [COORD_WIDTH-1:0] op_b,
   output logic signed [COORD_WIDTH+7:0] prod_ff
);

   localparam int FRAC_BITS = COORD_WIDTH - 8;
   localparam int PROD_W    = 2 * COORD_WIDTH;

   logic signed [PROD_W-1:0] full_prod;
   logic signed [COORD_WIDTH+7:0] prod_in;

   // dropping the low bits of a signed product rounds toward minus infinity
   assign full_prod = op_a * op_b;
   assign prod_in   = full_prod[PROD_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: sv/mbe_csr.sv
// mbe_csr: configuration registers of the escape-time block
// depends on mbe_pkg (csr index codes, reset values, cfg_type)

module mbe_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mbe_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output mbe_pkg::cfg_type                    cfg
);

   import mbe_pkg::*;

   logic [LIMIT_WIDTH-1:0]  iter_limit_ff;
   logic [LIMIT_WIDTH-1:0]  iter_limit_in;
   logic [RADIUS_WIDTH-1:0] escape_radius_sq_ff;
   logic [RADIUS_WIDTH-1:0] escape_radius_sq_in;

   assign csr_ready = 1'b1;

   always_comb begin
      iter_limit_in       = iter_limit_ff;
      escape_radius_sq_in = escape_radius_sq_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ITER_LIMIT: begin
               iter_limit_in = csr_wdata[LIMIT_WIDTH-1:0];
            end
            CSR_ESCAPE_RADIUS_SQ: begin
               escape_radius_sq_in = csr_wdata[RADIUS_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_limit_ff       <= ITER_LIMIT_RESET;
         escape_radius_sq_ff <= ESCAPE_RADIUS_SQ_RESET;
      end else begin
         iter_limit_ff       <= iter_limit_in;
         escape_radius_sq_ff <= escape_radius_sq_in;
      end
   end

   assign cfg.iter_limit       = iter_limit_ff;
   assign cfg.escape_radius_sq = escape_radius_sq_ff;

endmodule

// File: sv/mbe_core.sv
// mbe_core: sequencer and datapath for z = z*z + c around one shared multiplier
// depends on mbe_pkg (state_type, cfg_type) and mbe_mul

module mbe_core #(
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [COORD_WIDTH-1:0] c_real,
   input  logic signed [COORD_WIDTH-1:0] c_imag,
   input  mbe_pkg::cfg_type              cfg,
   output logic                          busy,
   output logic                          done,
   output logic [COUNT_WIDTH-1:0]        iteration_count,
   output logic                          in_set
);

   import mbe_pkg::*;

   localparam int SQ_W  = COORD_WIDTH + 8;
   localparam int SUM_W = COORD_WIDTH + 10;
   localparam int CMP_W = (SQ_W + 1 > RADIUS_WIDTH) ? SQ_W + 1 : RADIUS_WIDTH;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [SUM_W-1:0] v
   );
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = {{(SUM_W-COORD_WIDTH){1'b0}}, COORD_MAX};
      lo = {{(SUM_W-COORD_WIDTH){1'b1}}, COORD_MIN};
      if (v > hi) begin
         sat_coord = COORD_MAX;
      end else if (v < lo) begin
         sat_coord = COORD_MIN;
      end else begin
         sat_coord = v[COORD_WIDTH-1:0];
      end
   endfunction

   state_type state_ff;
   state_type state_in;

   logic signed [COORD_WIDTH-1:0] x_ff, x_in;
   logic signed [COORD_WIDTH-1:0] y_ff, y_in;
   logic signed [COORD_WIDTH-1:0] cr_ff, cr_in;
   logic signed [COORD_WIDTH-1:0] ci_ff, ci_in;
   logic signed [SQ_W-1:0]        xsq_ff, xsq_in;
   logic signed [SQ_W-1:0]        ysq_ff, ysq_in;
   logic signed [SQ_W-1:0]        xy_ff, xy_in;
   logic [COUNT_WIDTH-1:0]        n_ff, n_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic                          first_ff, first_in;

   logic signed [COORD_WIDTH-1:0] op_a;
   logic signed [COORD_WIDTH-1:0] op_b;
   logic signed [SQ_W-1:0]        prod;

   logic [COUNT_WIDTH-1:0]  limit;
   logic [SQ_W-1:0]         xsq_u;
   logic [SQ_W-1:0]         ysq_u;
   logic [CMP_W-1:0]        mag_sq;
   logic                    below;
   logic signed [SUM_W-1:0] x_sum;
   logic signed [SUM_W-1:0] y_sum;
   logic signed [SUM_W-1:0] xsq_ext;
   logic signed [SUM_W-1:0] ysq_ext;
   logic signed [SUM_W-1:0] xy_ext;
   logic signed [SUM_W-1:0] cr_ext;
   logic signed [SUM_W-1:0] ci_ext;

   mbe_mul #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_mul (
      .clock  (clock),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod_ff(prod)
   );

   assign limit  = cfg.iter_limit[COUNT_WIDTH-1:0];
   assign xsq_u  = xsq_ff;
   assign ysq_u  = ysq_ff;
   assign mag_sq = CMP_W'(xsq_u) + CMP_W'(ysq_u);
   assign below  = mag_sq < CMP_W'(cfg.escape_radius_sq);

   assign xsq_ext = {{(SUM_W-SQ_W){xsq_ff[SQ_W-1]}}, xsq_ff};
   assign ysq_ext = {{(SUM_W-SQ_W){ysq_ff[SQ_W-1]}}, ysq_ff};
   assign xy_ext  = {{(SUM_W-SQ_W){xy_ff[SQ_W-1]}}, xy_ff};
   assign cr_ext  = {{(SUM_W-COORD_WIDTH){cr_ff[COORD_WIDTH-1]}}, cr_ff};
   assign ci_ext  = {{(SUM_W-COORD_WIDTH){ci_ff[COORD_WIDTH-1]}}, ci_ff};
   assign x_sum   = xsq_ext - ysq_ext + cr_ext;
   assign y_sum   = (xy_ext <<< 1) + ci_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL_XX;
            end
         end
         ST_MUL_XX: begin
            state_in = ST_MUL_YY;
         end
         ST_MUL_YY: begin
            state_in = ST_MUL_XY;
         end
         ST_MUL_XY: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if ((first_ff || below) && (n_ff != limit)) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_MUL_XX;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and multiplier operands
   always_comb begin
      busy = (state_ff != ST_IDLE);
      done = (state_ff == ST_DONE);
      op_a = x_ff;
      op_b = x_ff;
      case (state_ff)
         ST_MUL_YY: begin
            op_a = y_ff;
            op_b = y_ff;
         end
         ST_MUL_XY: begin
            op_a = x_ff;
            op_b = y_ff;
         end
         default: begin
            op_a = x_ff;
            op_b = x_ff;
         end
      endcase
   end

   // datapath
   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      xsq_in   = xsq_ff;
      ysq_in   = ysq_ff;
      xy_in    = xy_ff;
      n_in     = n_ff;
      count_in = count_ff;
      first_in = first_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in     = c_real;
               y_in     = c_imag;
               cr_in    = c_real;
               ci_in    = c_imag;
               n_in     = '0;
               count_in = '0;
               first_in = 1'b1;
            end
         end
         ST_MUL_YY: begin
            xsq_in = prod;
         end
         ST_MUL_XY: begin
            ysq_in = prod;
         end
         ST_TEST: begin
            xy_in = prod;
            if (!first_ff && below) begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            x_in     = sat_coord(x_sum);
            y_in     = sat_coord(y_sum);
            n_in     = n_ff + 1'b1;
            first_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
         count_ff <= '0;
         first_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         count_ff <= count_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      cr_ff  <= cr_in;
      ci_ff  <= ci_in;
      xsq_ff <= xsq_in;
      ysq_ff <= ysq_in;
      xy_ff  <= xy_in;
   end

   assign iteration_count = count_ff;
   assign in_set          = (count_ff == limit);

`ifndef SYNTHESIS
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (n_ff == '0 && count_ff == '0 && first_ff))
      else $error("counters not cleared on item accept");

   a_count_le_n: assert property (@(posedge clock) disable iff (reset)
      busy |-> (count_ff <= n_ff))
      else $error("count ran ahead of iterations");

   a_n_le_limit: assert property (@(posedge clock) disable iff (reset)
      busy |-> (n_ff <= limit))
      else $error("iterations passed the limit");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done |=> (!done && !busy))
      else $error("result strobe longer than one cycle");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST && !first_ff && below) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("count missed an iteration below threshold");
`endif

endmodule
